FILE: sv/gsc_pkg.sv
// gsc_pkg: shared types, constants and the reach table for the
// gated score state classifier; no dependencies
`timescale 1ns / 1ps

package gsc_pkg;

  localparam int NUM_STATES    = 8;
  localparam int NUM_EVID      = 6;
  localparam int STATE_W       = 3;
  localparam int EVID_W        = 16;
  localparam int REG_W         = 17;
  localparam int RAW_W         = 18;
  localparam int SCORE_W       = 19;
  localparam int PHASE_W       = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE        = 3'd0,
    ST_WALL_FORM   = 3'd1,
    ST_ABSORBING   = 3'd2,
    ST_EXHAUSTING  = 3'd3,
    ST_WITHDRAWING = 3'd4,
    ST_BREAKING    = 3'd5,
    ST_REFILLING   = 3'd6,
    ST_STABILIZING = 3'd7
  } gsc_state_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_FORMING   = 3'd0,
    PH_ACTIVE    = 3'd1,
    PH_DEPLETING = 3'd2,
    PH_REFILLING = 3'd3,
    PH_WITHDRAWN = 3'd4,
    PH_FAILED    = 3'd5
  } wall_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_EXIT    = 3'd0,
    CFG_SWITCH_MARG  = 3'd1,
    CFG_IDLE_BASE    = 3'd2,
    CFG_FORMING_BASE = 3'd3,
    CFG_LIFE_GAIN    = 3'd4,
    CFG_STAY_BONUS   = 3'd5
  } cfg_idx_e;

  typedef logic [STATE_W-1:0] state_idx_t;
  typedef logic [EVID_W-1:0]  evid_t;
  typedef logic [REG_W-1:0]   reg_t;
  typedef logic [RAW_W-1:0]   raw_t;
  typedef logic [SCORE_W-1:0] score_t;

  typedef evid_t  [NUM_EVID-1:0]   evid_vec_t;
  typedef raw_t   [NUM_STATES-1:0] raw_vec_t;
  typedef score_t [NUM_STATES-1:0] score_vec_t;

  typedef struct packed {
    reg_t leave_idle_min;
    reg_t switch_margin;
    reg_t idle_base;
    reg_t forming_base;
    reg_t lifecycle_gain;
    reg_t stay_bonus;
  } cfg_t;

  typedef struct packed {
    state_idx_t new_state;
    logic       state_changed;
    score_t     top_score;
    state_idx_t second_state;
    score_t     second_score;
    reg_t       confidence;
  } result_t;

  // bit i set: state i reachable from the indexing state
  localparam logic [NUM_STATES-1:0] REACH [NUM_STATES] = '{
    8'h03, 8'h37, 8'h3F, 8'hAF, 8'h71, 8'hE1, 8'hE1, 8'h87
  };

endpackage

FILE: sv/gsc_score.sv
// gsc_score: raw scores, wall gating, lifecycle boost, reach mask and stay bonus
// depends on gsc_pkg
`timescale 1ns / 1ps

module gsc_score
  import gsc_pkg::*;
(
  input  evid_vec_t  evid_i,
  input  logic       wall_i,
  input  logic [PHASE_W-1:0] phase_i,
  input  state_idx_t prev_i,
  input  cfg_t       cfg_i,
  output raw_vec_t   raw_o,
  output score_vec_t score_o
);

  raw_vec_t pre;
  raw_t     gain;

  assign gain = RAW_W'(cfg_i.lifecycle_gain);

  always_comb begin
    pre    = '0;
    pre[0] = RAW_W'(cfg_i.idle_base);
    if (wall_i) begin
      pre[ST_WALL_FORM] = RAW_W'(cfg_i.forming_base);
      for (int i = 0; i < NUM_EVID; i++) begin
        pre[i + 2] = RAW_W'(evid_i[i]);
      end
      case (phase_i)
        PH_FORMING:   pre[ST_WALL_FORM]   = pre[ST_WALL_FORM] + gain;
        PH_REFILLING: pre[ST_REFILLING]   = pre[ST_REFILLING] + gain;
        PH_WITHDRAWN: pre[ST_WITHDRAWING] = pre[ST_WITHDRAWING] + gain;
        PH_FAILED:    pre[ST_BREAKING]    = pre[ST_BREAKING] + gain;
        default:      ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STATES; i++) begin
      raw_o[i]   = REACH[prev_i][i] ? pre[i] : '0;
      score_o[i] = SCORE_W'(raw_o[i]);
      if (prev_i == STATE_W'(i)) begin
        score_o[i] = SCORE_W'(raw_o[i]) + SCORE_W'(cfg_i.stay_bonus);
      end
    end
  end

endmodule

FILE: sv/gsc_argmax.sv
// gsc_argmax: winner and runner-up over eight scores, low index wins ties
// depends on gsc_pkg
`timescale 1ns / 1ps

module gsc_argmax
  import gsc_pkg::*;
(
  input  score_vec_t score_i,
  output state_idx_t best_o,
  output state_idx_t second_o
);

  state_idx_t best;
  state_idx_t second;

  always_comb begin
    best   = '0;
    second = '0;
    for (int i = 1; i < NUM_STATES; i++) begin
      if (score_i[i] > score_i[best]) begin
        second = best;
        best   = STATE_W'(i);
      end else if (score_i[i] > score_i[second] || second == best) begin
        second = STATE_W'(i);
      end
    end
  end

  assign best_o   = best;
  assign second_o = second;

endmodule

FILE: sv/gsc_gate.sv
// gsc_gate: idle exit and switch margin gates, confidence clamp
// depends on gsc_pkg
`timescale 1ns / 1ps

module gsc_gate
  import gsc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  state_idx_t prev_i,
  input  state_idx_t best_i,
  input  state_idx_t second_i,
  input  raw_vec_t   raw_i,
  input  score_vec_t score_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam int CW = (FRAC_BITS + 1 > SCORE_W) ? FRAC_BITS + 1 : SCORE_W;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

  state_idx_t     win_idle;
  state_idx_t     win;
  score_t         lead_need;
  score_t         diff;
  logic [CW-1:0]  diff_w;
  logic [CW-1:0]  conf_w;

  always_comb begin
    win_idle = best_i;
    if (prev_i == ST_IDLE && best_i != ST_IDLE &&
        score_i[best_i] < SCORE_W'(cfg_i.leave_idle_min)) begin
      win_idle = ST_IDLE;
    end
    lead_need = SCORE_W'(raw_i[prev_i]) + SCORE_W'(cfg_i.switch_margin);
    win = win_idle;
    if (win_idle != prev_i && SCORE_W'(raw_i[win_idle]) < lead_need) begin
      win = prev_i;
    end
  end

  always_comb begin
    diff   = (score_i[best_i] >= score_i[second_i]) ?
             score_i[best_i] - score_i[second_i] : '0;
    diff_w = CW'(diff);
    conf_w = (diff_w > ONE) ? ONE : diff_w;
  end

  always_comb begin
    result_o.new_state     = win;
    result_o.state_changed = (win != prev_i);
    result_o.top_score     = score_i[best_i];
    result_o.second_state  = second_i;
    result_o.second_score  = score_i[second_i];
    result_o.confidence    = conf_w[REG_W-1:0];
  end

endmodule

FILE: sv/gated_score_state_classifier.sv
// gated_score_state_classifier: top level, input and result registers, regime state
// depends on gsc_pkg, gsc_score, gsc_argmax, gsc_gate
`timescale 1ns / 1ps

// usage
//   input channel: in_valid_i with the six evidence scores, wall_present_i and
//   wall_phase_i; the block raises in_stall_o to hold an item back
//   result channel: out_valid_o with one result item per input item; the
//   receiver raises out_stall_i to hold the result, which stays unchanged
//   config: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is high,
//   only with no item in flight; indexes 6 and 7 are ignored
//   path: an accepted item is held in the input register and scored from it;
//   its result enters the result register and is offered on the result channel
//   throughput: one item per cycle unless the result is stalled; scoring,
//   argmax and gates are combinational between the input register and the
//   result register, and the regime state updates as each item is scored
//   stall: a stalled result holds; the input register still takes one more
//   item, after which in_stall_o follows out_stall_i
//   reset: regime state returns to idle, all config registers to zero,
//   both registers empty

module gated_score_state_classifier
  import gsc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [EVID_W-1:0]    absorption_i,
  input  logic [EVID_W-1:0]    exhaustion_i,
  input  logic [EVID_W-1:0]    withdrawal_i,
  input  logic [EVID_W-1:0]    breakout_i,
  input  logic [EVID_W-1:0]    refill_i,
  input  logic [EVID_W-1:0]    stabilization_i,
  input  logic                 wall_present_i,
  input  logic [PHASE_W-1:0]   wall_phase_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATE_W-1:0]   new_state_o,
  output logic                 state_changed_o,
  output logic [SCORE_W-1:0]   top_score_o,
  output logic [STATE_W-1:0]   second_state_o,
  output logic [SCORE_W-1:0]   second_score_o,
  output logic [REG_W-1:0]     confidence_o
);

  cfg_t               cfg_q, cfg_d;
  state_idx_t         state_q;
  logic               in_valid_q, in_valid_d;
  logic               out_valid_q, out_valid_d;
  evid_vec_t          evid_q;
  logic               wall_q;
  logic [PHASE_W-1:0] phase_q;
  result_t            result_q;

  logic       in_accept;
  logic       out_free;
  logic       fire;
  raw_vec_t   raw;
  score_vec_t score;
  state_idx_t best;
  state_idx_t second;
  result_t    result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDLE_EXIT:    cfg_d.leave_idle_min = cfg_wdata_i;
        CFG_SWITCH_MARG:  cfg_d.switch_margin  = cfg_wdata_i;
        CFG_IDLE_BASE:    cfg_d.idle_base      = cfg_wdata_i;
        CFG_FORMING_BASE: cfg_d.forming_base   = cfg_wdata_i;
        CFG_LIFE_GAIN:    cfg_d.lifecycle_gain = cfg_wdata_i;
        CFG_STAY_BONUS:   cfg_d.stay_bonus     = cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (fire) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      state_q     <= ST_IDLE;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= result.new_state;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      evid_q  <= {stabilization_i, refill_i, breakout_i,
                  withdrawal_i, exhaustion_i, absorption_i};
      wall_q  <= wall_present_i;
      phase_q <= wall_phase_i;
    end
    if (fire) begin
      result_q <= result;
    end
  end

  gsc_score u_score (
    .evid_i  (evid_q),
    .wall_i  (wall_q),
    .phase_i (phase_q),
    .prev_i  (state_q),
    .cfg_i   (cfg_q),
    .raw_o   (raw),
    .score_o (score)
  );

  gsc_argmax u_argmax (
    .score_i  (score),
    .best_o   (best),
    .second_o (second)
  );

  gsc_gate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_gate (
    .prev_i   (state_q),
    .best_i   (best),
    .second_i (second),
    .raw_i    (raw),
    .score_i  (score),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_valid_o     = out_valid_q;
  assign new_state_o     = result_q.new_state;
  assign state_changed_o = result_q.state_changed;
  assign top_score_o     = result_q.top_score;
  assign second_state_o  = result_q.second_state;
  assign second_score_o  = result_q.second_score;
  assign confidence_o    = result_q.confidence;

`ifndef SYNTHESIS
  a_state_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> state_q == new_state_o)
    else $error("regime state differs from last result");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("regime state changed without an item");

  a_pending_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(evid_q))
    else $error("pending item lost while result stalled");
`endif

endmodule
